FILE: rtl/hmt_pkg.sv
// Package for the heartbeat membership table: field widths, operation and
// result codes, register indexes, and the item, entry and cell-control types.
// No dependencies.
package hmt_pkg;

  localparam int OP_W       = 3;
  localparam int KIND_W     = 3;
  localparam int ID_W       = 8;
  localparam int PORT_W     = 16;
  localparam int HB_W       = 32;
  localparam int TIME_W     = 32;
  localparam int TO_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_JOIN_REQ   = 3'd0;
  localparam logic [OP_W-1:0] OP_JOIN_REPLY = 3'd1;
  localparam logic [OP_W-1:0] OP_PING       = 3'd2;
  localparam logic [OP_W-1:0] OP_GOSSIP     = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NO_CHANGE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_JOIN_SEND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PING_SEND = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd20;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   member_id;
    logic [PORT_W-1:0] member_port;
    logic [HB_W-1:0]   member_heartbeat;
    logic [TIME_W-1:0] member_stamp;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   target_id;
    logic [PORT_W-1:0] target_port;
    logic              was_added;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [HB_W-1:0]   heartbeat;
    logic [TIME_W-1:0] stamp;
  } entry_data_t;

  typedef struct packed {
    logic        valid;
    entry_data_t data;
  } entry_t;

  // Row-wide control broadcast to every cell
  typedef struct packed {
    logic shift_up;   // take the upper neighbor (ascending rotation)
    logic shift_dn;   // take the lower neighbor (descending rotation)
    logic sort;       // odd-even compaction round
    logic phase;      // parity of the lower cell of each active pair
  } cell_ctl_t;

  // Fixed position facts of one cell
  typedef struct packed {
    logic odd;
    logic has_up;
    logic has_dn;
  } cell_pos_t;

endpackage

FILE: rtl/hmt_cell.sv
// One slot of the membership row: holds an entry and trades it with its
// neighbors. Depends on hmt_pkg.
module hmt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  hmt_pkg::cell_ctl_t ctl,
  input  hmt_pkg::cell_pos_t pos,
  input  hmt_pkg::entry_t   up_ent,
  input  hmt_pkg::entry_t   dn_ent,
  output hmt_pkg::entry_t   ent
);
  import hmt_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  entry_data_t data_r;
  entry_data_t data_nxt;
  logic        take_up;
  logic        take_dn;

  // Compaction: a hole below a live entry swaps with it inside the active pair
  assign take_up = ctl.shift_up ||
                   (ctl.sort && (pos.odd == ctl.phase) && pos.has_up &&
                    !valid_r && up_ent.valid);
  assign take_dn = ctl.shift_dn ||
                   (ctl.sort && (pos.odd != ctl.phase) && pos.has_dn &&
                    !dn_ent.valid && valid_r);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take_up) begin
      valid_nxt = up_ent.valid;
      data_nxt  = up_ent.data;
    end else if (take_dn) begin
      valid_nxt = dn_ent.valid;
      data_nxt  = dn_ent.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign ent.valid = valid_r;
  assign ent.data  = data_r;

endmodule

FILE: rtl/heartbeat_membership_table.sv
// Heartbeat membership table top level: control sequencer over a rotating row
// of hmt_cell slots. Depends on hmt_pkg and hmt_cell.
// Flow: join request/reply, ping and gossip rotate the whole row once past
// the head cell, then report from the emit state; a join request adds a
// second result from a further emit state before busy falls.
// An in-group tick rotates the row the other way, one result per live member
// (an idle tick if the table is empty), and runs compaction rounds after it
// if anything was removed. Other items report in the cycle after the transfer.
// Results cannot be stalled. Synchronous reset empties the table, clears the
// group flag and loads the register defaults; no clearing pass is needed.
module heartbeat_membership_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  hmt_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output hmt_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hmt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hmt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_EMIT  = 6'b000100,
    ST_EMIT2 = 6'b001000,
    ST_TICK  = 6'b010000,
    ST_SORT  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  in_item_t          req_r;
  logic              ins_en_r, ins_en_nxt;
  logic              decided_r, decided_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              removed_r, removed_nxt;
  logic              in_group_r, in_group_nxt;
  logic [ID_W-1:0]   self_id_r;
  logic [PORT_W-1:0] self_port_r;
  logic [TO_W-1:0]   timeout_r;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic [TIME_W-1:0] timeout_ext;
  logic              in_is_self;
  logic              in_fresh;

  entry_t            ent_w [TABLE_DEPTH];
  cell_ctl_t         ctl_w;
  entry_t            scan_head;
  entry_t            tick_head;
  entry_t            fb_up;
  entry_t            fb_dn;
  logic              scan_match;
  logic              scan_ins;
  logic              hb_higher;
  logic [HB_W-1:0]   hb_inc;
  logic              tick_stale;
  logic [KIND_W-1:0] kind_final;

  assign accept      = start && !busy;
  assign busy        = (state_r != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_strobe  = out_strobe_r;
  assign out_item    = out_item_r;
  assign timeout_ext = {{(TIME_W-TO_W){1'b0}}, timeout_r};

  // Gossip admission, judged at transfer time
  assign in_is_self = (in_item.member_id == self_id_r) &&
                      (in_item.member_port == self_port_r);
  assign in_fresh   = (TIME_W'(in_item.now - in_item.member_stamp) < timeout_ext);
  assign ins_en_nxt = (in_item.operation != OP_GOSSIP) || (!in_is_self && in_fresh);

  // ---------------------------------------------------------------------
  // Row control: ascending rotation for lookups, descending for ticks
  // ---------------------------------------------------------------------
  assign ctl_w.shift_up = (state_r == ST_SCAN);
  assign ctl_w.shift_dn = (state_r == ST_TICK);
  assign ctl_w.sort     = (state_r == ST_SORT);
  assign ctl_w.phase    = step_r[0];

  // Lookup head: slot k sits in cell 0 after k ascending steps
  assign scan_head  = ent_w[0];
  assign scan_match = scan_head.valid &&
                      (scan_head.data.id == req_r.member_id) &&
                      (scan_head.data.port == req_r.member_port);
  // Live entries are packed low, so the first hole comes after every member
  assign scan_ins   = !scan_head.valid && !decided_r && ins_en_r;
  assign hb_higher  = (req_r.member_heartbeat > scan_head.data.heartbeat);
  assign hb_inc     = (scan_head.data.heartbeat == {HB_W{1'b1}}) ?
                      scan_head.data.heartbeat : scan_head.data.heartbeat + 1'b1;

  always_comb begin
    fb_up = scan_head;
    if (scan_match && (req_r.operation == OP_PING)) begin
      fb_up.data.heartbeat = hb_inc;
      fb_up.data.stamp     = req_r.now;
    end else if (scan_match && (req_r.operation == OP_GOSSIP) && hb_higher) begin
      fb_up.data.heartbeat = req_r.member_heartbeat;
      fb_up.data.stamp     = req_r.now;
    end else if (scan_ins) begin
      fb_up.valid     = 1'b1;
      fb_up.data.id   = req_r.member_id;
      fb_up.data.port = req_r.member_port;
      if (req_r.operation == OP_GOSSIP) begin
        fb_up.data.heartbeat = req_r.member_heartbeat;
        fb_up.data.stamp     = req_r.member_stamp;
      end else begin
        fb_up.data.heartbeat = HB_W'(1);
        fb_up.data.stamp     = req_r.now;
      end
    end
  end

  // Tick head: slot TABLE_DEPTH-1-k sits in the top cell after k descending steps
  assign tick_head  = ent_w[TABLE_DEPTH-1];
  assign tick_stale = (TIME_W'(req_r.now - tick_head.data.stamp) >= timeout_ext);

  always_comb begin
    fb_dn       = tick_head;
    fb_dn.valid = tick_head.valid && !tick_stale;  // drop stale members
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t    up_w;
    entry_t    dn_w;
    cell_pos_t pos_w;

    if (i == TABLE_DEPTH - 1) begin : g_top
      assign up_w = fb_up;
    end else begin : g_mid_up
      assign up_w = ent_w[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_w = fb_dn;
    end else begin : g_mid_dn
      assign dn_w = ent_w[i-1];
    end

    assign pos_w.odd    = 1'((i % 2) == 1);
    assign pos_w.has_up = 1'(i != TABLE_DEPTH - 1);
    assign pos_w.has_dn = 1'(i != 0);

    hmt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl_w),
      .pos    (pos_w),
      .up_ent (up_w),
      .dn_ent (dn_w),
      .ent    (ent_w[i])
    );
  end

  // Final lookup verdict: no match and no hole means full (if insertion allowed)
  assign kind_final = decided_r ? kind_r : (ins_en_r ? KIND_FULL : KIND_NO_CHANGE);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    decided_nxt    = decided_r;
    kind_nxt       = kind_r;
    removed_nxt    = removed_r;
    in_group_nxt   = in_group_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt    = '0;
          decided_nxt = 1'b0;
          removed_nxt = 1'b0;
          case (in_item.operation) inside
            OP_JOIN_REQ, OP_JOIN_REPLY, OP_PING, OP_GOSSIP: begin
              state_nxt = ST_SCAN;
            end
            OP_TICK: begin
              if (in_group_r) begin
                state_nxt = ST_TICK;
              end else begin
                // Report an idle tick right away
                out_strobe_nxt           = 1'b1;
                out_item_nxt.kind        = KIND_IDLE_TICK;
                out_item_nxt.target_id   = '0;
                out_item_nxt.target_port = '0;
                out_item_nxt.was_added   = 1'b0;
                out_item_nxt.last        = 1'b1;
              end
            end
            default: begin
              out_strobe_nxt           = 1'b1;
              out_item_nxt.kind        = KIND_NO_CHANGE;
              out_item_nxt.target_id   = in_item.member_id;
              out_item_nxt.target_port = in_item.member_port;
              out_item_nxt.was_added   = 1'b0;
              out_item_nxt.last        = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (scan_match) begin
          decided_nxt = 1'b1;
          kind_nxt    = ((req_r.operation == OP_PING) ||
                         ((req_r.operation == OP_GOSSIP) && hb_higher)) ?
                        KIND_UPDATED : KIND_NO_CHANGE;
        end else if (scan_ins) begin
          decided_nxt = 1'b1;
          kind_nxt    = KIND_INSERTED;
        end
        if (step_r == LAST_STEP) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        out_strobe_nxt           = 1'b1;
        out_item_nxt.kind        = kind_final;
        out_item_nxt.target_id   = req_r.member_id;
        out_item_nxt.target_port = req_r.member_port;
        out_item_nxt.was_added   = (req_r.operation == OP_JOIN_REQ) &&
                                   (kind_final == KIND_INSERTED);
        out_item_nxt.last        = (req_r.operation != OP_JOIN_REQ);
        kind_nxt                 = kind_final;
        if (req_r.operation == OP_JOIN_REPLY) begin
          in_group_nxt = 1'b1;
        end
        state_nxt = (req_r.operation == OP_JOIN_REQ) ? ST_EMIT2 : ST_IDLE;
      end

      ST_EMIT2: begin
        // Join reply to the requester follows its insert result
        out_strobe_nxt           = 1'b1;
        out_item_nxt.kind        = KIND_JOIN_SEND;
        out_item_nxt.target_id   = req_r.member_id;
        out_item_nxt.target_port = req_r.member_port;
        out_item_nxt.was_added   = (kind_r == KIND_INSERTED);
        out_item_nxt.last        = 1'b1;
        state_nxt                = ST_IDLE;
      end

      ST_TICK: begin
        step_nxt = step_r + 1'b1;
        if (tick_head.valid) begin
          out_strobe_nxt           = 1'b1;
          out_item_nxt.kind        = tick_stale ? KIND_REMOVED : KIND_PING_SEND;
          out_item_nxt.target_id   = tick_head.data.id;
          out_item_nxt.target_port = tick_head.data.port;
          out_item_nxt.was_added   = 1'b0;
          out_item_nxt.last        = (step_r == LAST_STEP);
          removed_nxt              = removed_r || tick_stale;
        end else if (step_r == LAST_STEP) begin
          // Slot 0 empty means the whole table is empty
          out_strobe_nxt           = 1'b1;
          out_item_nxt.kind        = KIND_IDLE_TICK;
          out_item_nxt.target_id   = '0;
          out_item_nxt.target_port = '0;
          out_item_nxt.was_added   = 1'b0;
          out_item_nxt.last        = 1'b1;
        end
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = (removed_r || (tick_head.valid && tick_stale)) ? ST_SORT : ST_IDLE;
        end
      end

      ST_SORT: begin
        // Close the holes left by removals; order of live members is kept
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      decided_r    <= 1'b0;
      kind_r       <= KIND_NO_CHANGE;
      removed_r    <= 1'b0;
      in_group_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      decided_r    <= decided_nxt;
      kind_r       <= kind_nxt;
      removed_r    <= removed_nxt;
      in_group_r   <= in_group_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Hold the item for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_item;
      ins_en_r <= ins_en_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // Configuration registers; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r   <= '0;
      self_port_r <= '0;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SELF_ID:   self_id_r   <= cfg_data[ID_W-1:0];
        CFG_SELF_PORT: self_port_r <= cfg_data[PORT_W-1:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[TO_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/hmt_checker.sv
// Port-level checks for the heartbeat membership table, bound to the top level.
// Depends on hmt_pkg and heartbeat_membership_table.
module hmt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input hmt_pkg::in_item_t   in_item,
  input logic                out_strobe,
  input hmt_pkg::out_item_t  out_item
);
  import hmt_pkg::*;

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_strobe)
    else $error("block not idle after reset");

  // A table lookup always occupies the block past its transfer
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy &&
    (in_item.operation == OP_JOIN_REQ || in_item.operation == OP_JOIN_REPLY ||
     in_item.operation == OP_PING || in_item.operation == OP_GOSSIP) |=> busy)
    else $error("lookup transfer did not start a scan");

  // Results of one item come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap inside a result burst");

  // A non-final result means the item is still in progress
  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> busy)
    else $error("non-final result while idle");

  // An idle tick names nobody and ends its item
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == KIND_IDLE_TICK |->
    out_item.target_id == '0 && out_item.target_port == '0 && out_item.last)
    else $error("malformed idle tick result");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

FILE: sim/heartbeat_membership_table_tb.sv
// Self-checking testbench for heartbeat_membership_table: a directed stimulus table
// followed by random membership traffic, checked against a predictor of the roster.
// Depends on hmt_pkg and the heartbeat_membership_table RTL.
module heartbeat_membership_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hmt_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int MEMBER_POOL  = 24;
  localparam int RUN_LIMIT_NS = 400000;

  // Operation codes the block does not define; each must report no change.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  heartbeat_membership_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Shadow of the membership roster and of the node's own registers.
  entry_t            roster [TABLE_DEPTH];
  logic              roster_in_group;
  logic [ID_W-1:0]   own_id;
  logic [PORT_W-1:0] own_port;
  logic [TO_W-1:0]   stale_age;

  // Results still owed by the block, oldest first.
  out_item_t pending_results[$];
  int        mismatch_count;

  // Random traffic: a small pool of members so that lookups hit, the roster
  // fills up and ticks find both live and stale entries.
  logic [ID_W-1:0]   pool_id   [MEMBER_POOL];
  logic [PORT_W-1:0] pool_port [MEMBER_POOL];
  logic [TIME_W-1:0] clock_now;
  int                gap_max;

  // Directed stimulus: one row per transfer. Where typed is set, kind is the
  // first result's kind as read straight off the behavior; the predictor
  // supplies everything else.
  typedef struct packed {
    in_item_t          item;
    logic              typed;
    logic [KIND_W-1:0] kind;
  } probe_row_t;

  probe_row_t probe_rows[$];

  function automatic void add_probe(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                    input logic [PORT_W-1:0] port,
                                    input logic [HB_W-1:0] hb,
                                    input logic [TIME_W-1:0] stamp,
                                    input logic [TIME_W-1:0] now, input logic typed,
                                    input logic [KIND_W-1:0] kind);
    probe_row_t row;
    row.item  = '{op, id, port, hb, stamp, now};
    row.typed = typed;
    row.kind  = kind;
    probe_rows.insert(probe_rows.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // Roster predictor
  // ---------------------------------------------------------------------------

  function automatic int find_member(input logic [ID_W-1:0] id,
                                     input logic [PORT_W-1:0] port);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (roster[i].valid && roster[i].data.id == id && roster[i].data.port == port)
        return i;
    return -1;
  endfunction

  // Append at the first free slot; a full roster drops the member.
  function automatic logic [KIND_W-1:0] append_member(input logic [ID_W-1:0] id,
                                                      input logic [PORT_W-1:0] port,
                                                      input logic [HB_W-1:0] hb,
                                                      input logic [TIME_W-1:0] stamp);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!roster[i].valid) begin
        roster[i] = {1'b1, id, port, hb, stamp};
        return KIND_INSERTED;
      end
    return KIND_FULL;
  endfunction

  // Close the gap: every higher slot moves down by one.
  function automatic void drop_member(input int slot);
    for (int i = slot; i < TABLE_DEPTH - 1; i++)
      roster[i] = roster[i + 1];
    roster[TABLE_DEPTH - 1] = '0;
  endfunction

  function automatic void owe_result(input logic [KIND_W-1:0] kind,
                                     input logic [ID_W-1:0] id,
                                     input logic [PORT_W-1:0] port, input logic added);
    out_item_t res;
    res.kind        = kind;
    res.target_id   = id;
    res.target_port = port;
    res.was_added   = added;
    res.last        = 1'b0;
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Advance the roster by one transfer and queue the results it causes.
  function automatic void predict_membership(input in_item_t it);
    int                slot;
    int                first;
    logic [KIND_W-1:0] kind;
    logic              added;
    logic [TIME_W-1:0] age;
    out_item_t         tail;
    first = pending_results.size();
    case (it.operation) inside
      OP_JOIN_REQ, OP_JOIN_REPLY: begin
        slot = find_member(it.member_id, it.member_port);
        if (slot >= 0) kind = KIND_NO_CHANGE;
        else kind = append_member(it.member_id, it.member_port, 1, it.now);
        if (it.operation == OP_JOIN_REQ) begin
          added = (kind == KIND_INSERTED);
          owe_result(kind, it.member_id, it.member_port, added);
          owe_result(KIND_JOIN_SEND, it.member_id, it.member_port, added);
        end else begin
          owe_result(kind, it.member_id, it.member_port, 1'b0);
          roster_in_group = 1'b1;
        end
      end
      OP_PING: begin
        slot = find_member(it.member_id, it.member_port);
        if (slot >= 0) begin
          // Heartbeat saturates at all ones.
          if (roster[slot].data.heartbeat != '1)
            roster[slot].data.heartbeat = roster[slot].data.heartbeat + 1;
          roster[slot].data.stamp = it.now;
          kind = KIND_UPDATED;
        end else begin
          kind = append_member(it.member_id, it.member_port, 1, it.now);
        end
        owe_result(kind, it.member_id, it.member_port, 1'b0);
      end
      OP_GOSSIP: begin
        slot = find_member(it.member_id, it.member_port);
        kind = KIND_NO_CHANGE;
        age  = it.now - it.member_stamp;
        if (slot >= 0) begin
          if (it.member_heartbeat > roster[slot].data.heartbeat) begin
            roster[slot].data.heartbeat = it.member_heartbeat;
            roster[slot].data.stamp     = it.now;
            kind = KIND_UPDATED;
          end
        end else if (!(it.member_id == own_id && it.member_port == own_port) &&
                     age < {16'd0, stale_age}) begin
          kind = append_member(it.member_id, it.member_port, it.member_heartbeat,
                               it.member_stamp);
        end
        owe_result(kind, it.member_id, it.member_port, 1'b0);
      end
      OP_TICK: begin
        // Scan top slot down; removal only shifts slots already visited.
        if (roster_in_group)
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (roster[i].valid) begin
              age = it.now - roster[i].data.stamp;
              if (age >= {16'd0, stale_age}) begin
                owe_result(KIND_REMOVED, roster[i].data.id, roster[i].data.port, 1'b0);
                drop_member(i);
              end else begin
                owe_result(KIND_PING_SEND, roster[i].data.id, roster[i].data.port, 1'b0);
              end
            end
        if (pending_results.size() == first)
          owe_result(KIND_IDLE_TICK, '0, '0, 1'b0);
      end
      default: owe_result(KIND_NO_CHANGE, it.member_id, it.member_port, 1'b0);
    endcase
    // Mark the final result of this transfer.
    tail      = pending_results.pop_back();
    tail.last = 1'b1;
    pending_results.insert(pending_results.size(), tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold start high until a transfer happens (start high, busy low at the
  // edge). Start stays high afterwards so back-to-back items need no second
  // assignment in the same step; lower it before a gap or at phase end.
  task automatic send_item(input in_item_t item, input logic typed,
                           input logic [KIND_W-1:0] kind);
    int        gap;
    int        first;
    out_item_t head;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    first = pending_results.size();
    predict_membership(item);
    if (typed) begin
      head      = pending_results[first];
      head.kind = kind;
      pending_results[first] = head;
    end
  endtask

  // Wait until the block owes nothing and has finished any compaction rounds.
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_SELF_ID:   own_id    = value[ID_W-1:0];
      CFG_SELF_PORT: own_port  = value;
      CFG_TIMEOUT:   stale_age = value;
      default: ;
    endcase
  endtask

  // Reprogram the node only once the block has gone quiet.
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] id_word,
                             input logic [CFG_DATA_W-1:0] port_word,
                             input logic [CFG_DATA_W-1:0] age_word);
    settle();
    write_register(CFG_SELF_ID, id_word);
    write_register(CFG_SELF_PORT, port_word);
    write_register(CFG_TIMEOUT, age_word);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed membership traffic from the pool; about one in ten
  // items is noise: spare opcodes or strangers with random id and port.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       roll;
    if ($urandom_range(0, 15) == 0) clock_now = $urandom();
    else clock_now = clock_now + $urandom_range(0, stale_age / 4 + 1);
    pick = $urandom_range(0, MEMBER_POOL - 1);
    roll = $urandom_range(0, 99);
    it.member_id        = pool_id[pick];
    it.member_port      = pool_port[pick];
    it.member_heartbeat = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 40);
    it.member_stamp     = ($urandom_range(0, 7) == 0) ? $urandom() :
                          clock_now - $urandom_range(0, 2 * stale_age + 2);
    it.now              = clock_now;
    if (roll < 14)      it.operation = OP_JOIN_REQ;
    else if (roll < 22) it.operation = OP_JOIN_REPLY;
    else if (roll < 46) it.operation = OP_PING;
    else if (roll < 72) it.operation = OP_GOSSIP;
    else if (roll < 90) it.operation = OP_TICK;
    else begin
      it.operation   = OP_W'($urandom_range(OP_JOIN_REQ, OP_SPARE_C));
      it.member_id   = ID_W'($urandom());
      it.member_port = PORT_W'($urandom());
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_item(random_item(), 1'b0, KIND_NO_CHANGE);
    start <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is compared with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d id %0h port %0h", out_item.kind,
               out_item.target_id, out_item.target_port);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          mismatch_count++;
        end
        if (out_item.target_id !== want.target_id) begin
          $error("target_id: expected %0h, got %0h", want.target_id, out_item.target_id);
          mismatch_count++;
        end
        if (out_item.target_port !== want.target_port) begin
          $error("target_port: expected %0h, got %0h", want.target_port,
                 out_item.target_port);
          mismatch_count++;
        end
        if (out_item.was_added !== want.was_added) begin
          $error("was_added: expected %0b, got %0b", want.was_added, out_item.was_added);
          mismatch_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_item.last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SELF_ID;
    cfg_data  <= '0;

    foreach (roster[i]) roster[i] = '0;
    roster_in_group = 1'b0;
    own_id          = '0;
    own_port        = '0;
    stale_age       = TIMEOUT_RESET;
    mismatch_count  = 0;
    clock_now       = 32'd200;
    gap_max         = 3;
    foreach (pool_id[i]) begin
      pool_id[i]   = ID_W'($urandom());
      pool_port[i] = PORT_W'($urandom());
    end

    // Defaults after reset: self is 0/0, timeout 20, not in group.
    add_probe(OP_TICK,       8'h00, 16'h0000, 32'd0, 32'd0, 32'd90, 1'b1, KIND_IDLE_TICK);
    // Self named in gossip is never taken in.
    add_probe(OP_GOSSIP,     8'h00, 16'h0000, 32'd5, 32'd100, 32'd100, 1'b1, KIND_NO_CHANGE);
    // Self named in a join is inserted like anyone else.
    add_probe(OP_JOIN_REQ,   8'h00, 16'h0000, 32'd0, 32'd0, 32'd100, 1'b1, KIND_INSERTED);
    add_probe(OP_JOIN_REQ,   8'h00, 16'h0000, 32'd0, 32'd0, 32'd100, 1'b1, KIND_NO_CHANGE);
    add_probe(OP_JOIN_REPLY, 8'hFF, 16'hFFFF, 32'd0, 32'd0, 32'd101, 1'b1, KIND_INSERTED);
    add_probe(OP_PING,       8'hFF, 16'hFFFF, 32'd0, 32'd0, 32'd102, 1'b1, KIND_UPDATED);
    add_probe(OP_PING,       8'h12, 16'h3456, 32'd0, 32'd0, 32'd103, 1'b1, KIND_INSERTED);
    // Max heartbeat, then a ping: it must saturate, so the same heartbeat
    // gossiped again is not higher.
    add_probe(OP_GOSSIP, 8'hAA, 16'h5555, 32'hFFFF_FFFF, 32'd100, 32'd110, 1'b1,
              KIND_INSERTED);
    add_probe(OP_PING,   8'hAA, 16'h5555, 32'd0, 32'd0, 32'd111, 1'b1, KIND_UPDATED);
    add_probe(OP_GOSSIP, 8'hAA, 16'h5555, 32'hFFFF_FFFF, 32'd0, 32'd112, 1'b1,
              KIND_NO_CHANGE);
    add_probe(OP_GOSSIP, 8'hFF, 16'hFFFF, 32'd0, 32'd0, 32'd112, 1'b1, KIND_NO_CHANGE);
    add_probe(OP_GOSSIP, 8'hFF, 16'hFFFF, 32'd7, 32'd0, 32'd113, 1'b1, KIND_UPDATED);
    // Gossiped member exactly at the timeout is stale; one unit younger is fresh.
    add_probe(OP_GOSSIP, 8'h55, 16'hAAAA, 32'd3, 32'd93, 32'd113, 1'b1, KIND_NO_CHANGE);
    add_probe(OP_GOSSIP, 8'h55, 16'hAAAA, 32'd3, 32'd94, 32'd113, 1'b1, KIND_INSERTED);
    // Age across the time wrap, and a stamp ahead of now.
    add_probe(OP_GOSSIP, 8'h01, 16'h0001, 32'd9, 32'hFFFF_FFF0, 32'd2, 1'b0, KIND_NO_CHANGE);
    add_probe(OP_GOSSIP, 8'h02, 16'h0002, 32'd9, 32'd119, 32'd114, 1'b0, KIND_NO_CHANGE);
    // Spare opcodes report no change, with all-zero and all-one fields.
    add_probe(OP_SPARE_A, 8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, KIND_NO_CHANGE);
    add_probe(OP_SPARE_B, 8'h5A, 16'hA5A5, 32'h5555_AAAA, 32'hAAAA_5555, 32'd114, 1'b1,
              KIND_NO_CHANGE);
    add_probe(OP_SPARE_C, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, KIND_NO_CHANGE);
    // In group: a mix of pings and removals, then everyone stale, then empty.
    add_probe(OP_TICK, 8'h00, 16'h0000, 32'd0, 32'd0, 32'd115, 1'b0, KIND_NO_CHANGE);
    add_probe(OP_TICK, 8'h00, 16'h0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, KIND_NO_CHANGE);
    add_probe(OP_TICK, 8'h00, 16'h0000, 32'd0, 32'd0, 32'd120, 1'b1, KIND_IDLE_TICK);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[r])
      send_item(probe_rows[r].item, probe_rows[r].typed, probe_rows[r].kind);
    start <= 1'b0;

    // Top-end registers: the longest timeout keeps members alive, so the
    // roster fills and overflows. Upper bits of the id word must be ignored.
    reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(30);

    // Shortest nonzero timeout, back-to-back transfers.
    gap_max = 0;
    reconfigure(16'h005A, CFG_DATA_W'($urandom()), 16'd1);
    run_random(20);
    gap_max = 3;

    // Zero timeout: every member stale at a tick, no gossip ever fresh.
    // Self is a pool member from here on so gossip about it gets filtered.
    reconfigure({8'h00, pool_id[3]}, pool_port[3], 16'd0);
    run_random(10);

    reconfigure({8'hA5, pool_id[3]}, pool_port[3], CFG_DATA_W'($urandom_range(8, 64)));
    run_random(40);

    settle();
    if (mismatch_count == 0)
      $display("heartbeat_membership_table_tb passed");
    else
      $display("heartbeat_membership_table_tb failed");
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #RUN_LIMIT_NS;
    $display("heartbeat_membership_table_tb failed");
    $finish;
  end

endmodule
